FILE: rtl/core/dtae_pkg.sv
// Shared types, codes and constants for the DNS TXT answer extractor.
package dtae_pkg;

   // Message framing limits
   localparam int MAX_MSG   = 1024;
   localparam int MSG_CNT_W = $clog2(MAX_MSG + 1);

   // Fixed field lengths and byte positions inside them
   localparam int HDR_LEN     = 12;
   localparam int QD_HI_POS   = 4;
   localparam int QD_LO_POS   = 5;
   localparam int AN_HI_POS   = 6;
   localparam int AN_LO_POS   = 7;
   localparam int QFIX_LEN    = 4;
   localparam int AFIX_LEN    = 10;
   localparam int TYPE_HI_POS = 0;
   localparam int TYPE_LO_POS = 1;
   localparam int RDLEN_POS   = 8;
   localparam int FIELD_IDX_W = 4;

   // Label length byte top bits
   localparam logic [1:0] LBL_PTR = 2'b11;
   localparam logic [1:0] LBL_STD = 2'b00;

   // Result kinds
   localparam logic [1:0] KIND_TEXT   = 2'd0;
   localparam logic [1:0] KIND_EOR    = 2'd1;
   localparam logic [1:0] KIND_STATUS = 2'd2;

   // Message status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_BAD   = 2'd1;
   localparam logic [1:0] ST_NONE  = 2'd2;

   // Configuration register map
   localparam int          CSR_ADDR_W          = 3;
   localparam logic [2:0]  REG_MATCH_TYPE_ADDR = 3'd0;
   localparam logic [15:0] MATCH_TYPE_RESET    = 16'd16;

   // All results caused by one message byte, emitted in field order
   typedef struct packed {
      logic       has_text;
      logic [7:0] text;
      logic       has_eor;
      logic       has_stat;
      logic [1:0] stat;
   } bundle_type;

endpackage

FILE: rtl/core/dtae_parse.sv
// Message parser: per-byte state update and result bundle generation.
module dtae_parse (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 byte_accept,
   input  logic [7:0]           msg_byte,
   input  logic                 msg_end,
   input  logic [15:0]          match_type,
   output logic                 bundle_push,
   output dtae_pkg::bundle_type bundle
);
   import dtae_pkg::*;

   typedef enum logic [3:0] {
      PH_HDR   = 4'd0,
      PH_NAME  = 4'd1,
      PH_LABEL = 4'd2,
      PH_PTR   = 4'd3,
      PH_QFIX  = 4'd4,
      PH_AFIX  = 4'd5,
      PH_RSKIP = 4'd6,
      PH_SLEN  = 4'd7,
      PH_SDATA = 4'd8,
      PH_DONE  = 4'd9,
      PH_DRAIN = 4'd10
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [FIELD_IDX_W-1:0] fidx_ff, fidx_in;
   logic [7:0]             hold_ff, hold_in;
   logic [15:0]            qleft_ff, qleft_in;
   logic [15:0]            aleft_ff, aleft_in;
   logic [15:0]            rtype_ff, rtype_in;
   logic [15:0]            rleft_ff, rleft_in;
   logic [7:0]             sleft_ff, sleft_in;
   logic                   found_ff, found_in;
   logic [MSG_CNT_W-1:0]   seen_ff, seen_in;

   logic [15:0]            rleft_dec;
   logic [7:0]             sleft_dec;
   logic [15:0]            aleft_dec;
   logic [FIELD_IDX_W-1:0] fidx_inc;
   bundle_type             bnd;

   assign rleft_dec = rleft_ff - 16'd1;
   assign sleft_dec = sleft_ff - 8'd1;
   assign aleft_dec = aleft_ff - 16'd1;
   assign fidx_inc  = fidx_ff + FIELD_IDX_W'(1);

   // Next state and results for the byte being transferred
   always_comb begin
      phase_in = phase_ff;
      fidx_in  = fidx_ff;
      hold_in  = hold_ff;
      qleft_in = qleft_ff;
      aleft_in = aleft_ff;
      rtype_in = rtype_ff;
      rleft_in = rleft_ff;
      sleft_in = sleft_ff;
      found_in = found_ff;
      seen_in  = seen_ff;
      bnd      = '0;
      bnd.text = msg_byte;

      // Drop into drain once the size limit is passed
      if (seen_ff >= MSG_CNT_W'(MAX_MSG)) begin
         phase_in = PH_DRAIN;
      end else begin
         seen_in = seen_ff + MSG_CNT_W'(1);
         case (phase_ff)
            PH_HDR: begin
               if (fidx_ff == FIELD_IDX_W'(QD_HI_POS) || fidx_ff == FIELD_IDX_W'(AN_HI_POS)) begin
                  hold_in = msg_byte;
               end else if (fidx_ff == FIELD_IDX_W'(QD_LO_POS)) begin
                  qleft_in = {hold_ff, msg_byte};
               end else if (fidx_ff == FIELD_IDX_W'(AN_LO_POS)) begin
                  aleft_in = {hold_ff, msg_byte};
               end
               fidx_in = fidx_inc;
               if (fidx_inc >= FIELD_IDX_W'(HDR_LEN)) begin
                  fidx_in = '0;
                  if (qleft_ff != 16'd0 || aleft_ff != 16'd0) begin
                     phase_in = PH_NAME;
                  end else begin
                     phase_in = PH_DONE;
                  end
               end
            end
            PH_NAME: begin
               if (msg_byte[7:6] == LBL_PTR) begin
                  phase_in = PH_PTR;
               end else if (msg_byte[7:6] != LBL_STD) begin
                  phase_in = PH_DRAIN;
               end else if (msg_byte == 8'd0) begin
                  fidx_in  = '0;
                  phase_in = (qleft_ff != 16'd0) ? PH_QFIX : PH_AFIX;
               end else begin
                  sleft_in = msg_byte;
                  phase_in = PH_LABEL;
               end
            end
            PH_LABEL: begin
               sleft_in = sleft_dec;
               if (sleft_dec == 8'd0) begin
                  phase_in = PH_NAME;
               end
            end
            PH_PTR: begin
               fidx_in  = '0;
               phase_in = (qleft_ff != 16'd0) ? PH_QFIX : PH_AFIX;
            end
            PH_QFIX: begin
               fidx_in = fidx_inc;
               if (fidx_inc >= FIELD_IDX_W'(QFIX_LEN)) begin
                  fidx_in  = '0;
                  qleft_in = qleft_ff - 16'd1;
                  if (qleft_ff != 16'd1 || aleft_ff != 16'd0) begin
                     phase_in = PH_NAME;
                  end else begin
                     phase_in = PH_DONE;
                  end
               end
            end
            PH_AFIX: begin
               if (fidx_ff == FIELD_IDX_W'(TYPE_HI_POS) || fidx_ff == FIELD_IDX_W'(RDLEN_POS)) begin
                  hold_in = msg_byte;
               end else if (fidx_ff == FIELD_IDX_W'(TYPE_LO_POS)) begin
                  rtype_in = {hold_ff, msg_byte};
               end else if (fidx_ff == FIELD_IDX_W'(RDLEN_POS + 1)) begin
                  rleft_in = {hold_ff, msg_byte};
               end
               fidx_in = fidx_inc;
               if (fidx_inc >= FIELD_IDX_W'(AFIX_LEN)) begin
                  fidx_in = '0;
                  if (rtype_ff == match_type) begin
                     found_in = 1'b1;
                     if (rleft_in == 16'd0) begin
                        bnd.has_eor = 1'b1;
                        aleft_in    = aleft_dec;
                        phase_in    = (aleft_dec == 16'd0) ? PH_DONE : PH_NAME;
                     end else begin
                        phase_in = PH_SLEN;
                     end
                  end else if (rleft_in == 16'd0) begin
                     aleft_in = aleft_dec;
                     phase_in = (aleft_dec == 16'd0) ? PH_DONE : PH_NAME;
                  end else begin
                     phase_in = PH_RSKIP;
                  end
               end
            end
            PH_RSKIP: begin
               rleft_in = rleft_dec;
               if (rleft_dec == 16'd0) begin
                  aleft_in = aleft_dec;
                  phase_in = (aleft_dec == 16'd0) ? PH_DONE : PH_NAME;
               end
            end
            PH_SLEN: begin
               rleft_in = rleft_dec;
               if ({8'd0, msg_byte} > rleft_dec) begin
                  phase_in = PH_DRAIN;
               end else if (msg_byte != 8'd0) begin
                  sleft_in = msg_byte;
                  phase_in = PH_SDATA;
               end else if (rleft_dec == 16'd0) begin
                  bnd.has_eor = 1'b1;
                  aleft_in    = aleft_dec;
                  phase_in    = (aleft_dec == 16'd0) ? PH_DONE : PH_NAME;
               end
            end
            PH_SDATA: begin
               bnd.has_text = 1'b1;
               rleft_in     = rleft_dec;
               sleft_in     = sleft_dec;
               if (sleft_dec == 8'd0) begin
                  if (rleft_dec == 16'd0) begin
                     bnd.has_eor = 1'b1;
                     aleft_in    = aleft_dec;
                     phase_in    = (aleft_dec == 16'd0) ? PH_DONE : PH_NAME;
                  end else begin
                     phase_in = PH_SLEN;
                  end
               end
            end
            default: begin
            end
         endcase
      end

      // Close the message: give status and clear the parse state
      if (msg_end) begin
         bnd.has_stat = 1'b1;
         if (phase_in != PH_DONE) begin
            bnd.stat = ST_BAD;
         end else begin
            bnd.stat = found_in ? ST_OK : ST_NONE;
         end
         phase_in = PH_HDR;
         fidx_in  = '0;
         hold_in  = '0;
         qleft_in = '0;
         aleft_in = '0;
         rtype_in = '0;
         rleft_in = '0;
         sleft_in = '0;
         found_in = 1'b0;
         seen_in  = '0;
      end
   end

   assign bundle      = bnd;
   assign bundle_push = byte_accept & (bnd.has_text | bnd.has_eor | bnd.has_stat);

   // Hold parse state, advance on each transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HDR;
         fidx_ff  <= '0;
         hold_ff  <= '0;
         qleft_ff <= '0;
         aleft_ff <= '0;
         rtype_ff <= '0;
         rleft_ff <= '0;
         sleft_ff <= '0;
         found_ff <= 1'b0;
         seen_ff  <= '0;
      end else if (byte_accept) begin
         phase_ff <= phase_in;
         fidx_ff  <= fidx_in;
         hold_ff  <= hold_in;
         qleft_ff <= qleft_in;
         aleft_ff <= aleft_in;
         rtype_ff <= rtype_in;
         rleft_ff <= rleft_in;
         sleft_ff <= sleft_in;
         found_ff <= found_in;
         seen_ff  <= seen_in;
      end
   end

endmodule

FILE: rtl/core/dtae_rsp_queue.sv
// Two-entry result bundle queue and serializer onto the result stream.
module dtae_rsp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 bundle_push,
   input  dtae_pkg::bundle_type bundle,
   output logic                 space_ok,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [1:0]           rsp_kind,
   output logic [7:0]           rsp_text,
   output logic [1:0]           rsp_status,
   output logic                 rsp_last
);
   import dtae_pkg::*;

   bundle_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       sent_text_ff, sent_text_in;
   logic       sent_eor_ff, sent_eor_in;

   bundle_type head;
   logic       text_pend;
   logic       eor_pend;
   logic       part_xfer;
   logic       bundle_pop;

   assign head      = slot_ff[rd_ptr_ff];
   assign text_pend = head.has_text & ~sent_text_ff;
   assign eor_pend  = head.has_eor & ~sent_eor_ff;
   assign space_ok  = (count_ff != 2'd2);
   assign rsp_tvalid = (count_ff != 2'd0);

   // Pick the next part of the head bundle: text, end of record, status
   always_comb begin
      rsp_kind   = KIND_STATUS;
      rsp_text   = 8'd0;
      rsp_status = head.stat;
      rsp_last   = 1'b1;
      if (text_pend) begin
         rsp_kind   = KIND_TEXT;
         rsp_text   = head.text;
         rsp_status = ST_OK;
         rsp_last   = ~head.has_eor & ~head.has_stat;
      end else if (eor_pend) begin
         rsp_kind   = KIND_EOR;
         rsp_status = ST_OK;
         rsp_last   = ~head.has_stat;
      end
   end

   assign part_xfer  = rsp_tvalid & rsp_tready;
   assign bundle_pop = part_xfer & rsp_last;

   // Pointer, count and sent-part tracking
   always_comb begin
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      count_in     = count_ff;
      sent_text_in = sent_text_ff;
      sent_eor_in  = sent_eor_ff;
      if (bundle_push) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (bundle_pop) begin
         rd_ptr_in    = ~rd_ptr_ff;
         sent_text_in = 1'b0;
         sent_eor_in  = 1'b0;
      end else if (part_xfer) begin
         if (text_pend) begin
            sent_text_in = 1'b1;
         end else begin
            sent_eor_in = 1'b1;
         end
      end
      if (bundle_push && !bundle_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!bundle_push && bundle_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= 1'b0;
         rd_ptr_ff    <= 1'b0;
         count_ff     <= 2'd0;
         sent_text_ff <= 1'b0;
         sent_eor_ff  <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
         sent_text_ff <= sent_text_in;
         sent_eor_ff  <= sent_eor_in;
      end
   end

   // Store pushed bundles
   always_ff @(posedge clock) begin
      if (bundle_push) begin
         slot_ff[wr_ptr_ff] <= bundle;
      end
   end

endmodule

FILE: rtl/core/dns_txt_answer_extractor_core.sv
// Top level: DNS response parser emitting matching answer record text.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_tvalid/req_tready | msg_byte in tdata, msg_end in tlast
//   rsp     | out       | rsp_tvalid/rsp_tready | text_byte, status in tdata; out_kind in
//           |           |                       | tuser; run_last in tlast
//   csr     | in        | psel/penable, pready  | match_type at byte address 0
//
// One message byte is taken per cycle while the queue has room; its state update
// is done in the cycle of the transfer and its results (up to three) go into a
// two-bundle queue. Each result takes one rsp transfer, so a byte that gives two
// or three results takes two or three transfers; the queue depth sets how far the
// input runs ahead. reset is synchronous and clears parse state, queue and
// match_type (to 16). req_tready depends only on queue occupancy.
module dns_txt_answer_extractor_core (
   input  logic                            clock,
   input  logic                            reset,
   // req_tdata: [7:0] msg_byte
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,
   input  logic                            req_tlast,
   // rsp_tdata: [7:0] text_byte, [9:8] status, [15:10] zero
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [15:0]                     rsp_tdata,
   // rsp_tuser: [1:0] out_kind
   output logic [1:0]                      rsp_tuser,
   output logic                            rsp_tlast,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [dtae_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   import dtae_pkg::*;

   logic [15:0] match_type_ff;
   logic        byte_accept;
   logic        bundle_push;
   bundle_type  bundle;
   logic        space_ok;
   logic        match_sel;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_text;
   logic [1:0]  rsp_status;

   // Configuration register, decoded by word
   assign csr_pready = 1'b1;
   assign match_sel  = (csr_paddr[CSR_ADDR_W-1:2] == REG_MATCH_TYPE_ADDR[CSR_ADDR_W-1:2]);
   assign csr_prdata = match_sel ? {16'd0, match_type_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         match_type_ff <= MATCH_TYPE_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && match_sel) begin
         match_type_ff <= csr_pwdata[15:0];
      end
   end

   // Take a byte whenever the queue has room for its results
   assign req_tready  = space_ok;
   assign byte_accept = req_tvalid & req_tready;

   dtae_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (byte_accept),
      .msg_byte    (req_tdata),
      .msg_end     (req_tlast),
      .match_type  (match_type_ff),
      .bundle_push (bundle_push),
      .bundle      (bundle)
   );

   dtae_rsp_queue u_rsp_queue (
      .clock       (clock),
      .reset       (reset),
      .bundle_push (bundle_push),
      .bundle      (bundle),
      .space_ok    (space_ok),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_kind    (rsp_kind),
      .rsp_text    (rsp_text),
      .rsp_status  (rsp_status),
      .rsp_last    (rsp_tlast)
   );

   // Pack result fields
   assign rsp_tdata = {6'd0, rsp_status, rsp_text};
   assign rsp_tuser = rsp_kind;

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the DNS answer text extractor core.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dtae_pkg::*;

   // Message layout as seen on the wire
   localparam int HEADER_BYTES   = 12;
   localparam int QD_HI_AT       = 4;
   localparam int QD_LO_AT       = 5;
   localparam int AN_HI_AT       = 6;
   localparam int AN_LO_AT       = 7;
   localparam int QUESTION_TAIL  = 4;
   localparam int ANSWER_TAIL    = 10;
   localparam int RTYPE_HI_AT    = 0;
   localparam int RTYPE_LO_AT    = 1;
   localparam int RDLEN_AT       = 8;
   localparam int MSG_LIMIT      = 1024;
   localparam logic [15:0] TYPE_TXT = 16'd16;
   localparam logic [15:0] TYPE_A   = 16'd1;

   // Run control
   localparam int IDLE_PCT      = 18;
   localparam int HOLD_CYCLES   = 80;
   localparam int SETTLE_CYCLES = 10;
   localparam int STALL_LIMIT   = 2000;
   localparam int PRINT_CAP     = 100;
   localparam int PHASE_BYTES   = 15;

   typedef logic [7:0] byte_q_type[$];

   typedef enum logic [3:0] {
      P_HEADER, P_NAME_LEN, P_LABEL, P_POINTER, P_QUESTION_TAIL, P_ANSWER_TAIL,
      P_RDATA_SKIP, P_STRING_LEN, P_STRING_TEXT, P_ANSWERS_DONE, P_DRAIN
   } parse_step_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] text;
      logic [1:0] st;
      logic       run_last;
   } txt_result_type;

   // Tracks the parser state and holds the results still owed by the block
   class txt_scoreboard;
      logic [15:0]    match_type = MATCH_TYPE_RESET;
      parse_step_type step;
      int unsigned    idx;
      logic [7:0]     hold;
      logic [15:0]    qd_left, an_left, rtype, rd_left;
      logic [7:0]     str_left;
      bit             found, bad;
      int unsigned    seen;
      txt_result_type owed_q[$];
      int             errors;

      function new();
         restart();
      endfunction

      function void restart();
         step = P_HEADER;
         idx = 0;
         hold = '0;
         qd_left = '0;
         an_left = '0;
         rtype = '0;
         rd_left = '0;
         str_left = '0;
         found = 0;
         bad = 0;
         seen = 0;
      endfunction

      function int pending();
         return owed_q.size();
      endfunction

      function void push_result(logic [1:0] kind, logic [7:0] text, logic [1:0] st);
         owed_q.push_back('{kind: kind, text: text, st: st, run_last: 1'b0});
      endfunction

      function void go_bad();
         bad = 1;
         step = P_DRAIN;
      endfunction

      function void close_answer();
         an_left = an_left - 16'd1;
         step = (an_left == 0) ? P_ANSWERS_DONE : P_NAME_LEN;
      endfunction

      function void close_name();
         idx = 0;
         step = (qd_left != 0) ? P_QUESTION_TAIL : P_ANSWER_TAIL;
      endfunction

      // Advance the parser by one accepted message byte
      function void note_byte(logic [7:0] b, logic last);
         int         owed_before;
         logic [1:0] st;
         owed_before = owed_q.size();
         if (seen >= MSG_LIMIT) go_bad();
         else seen++;
         case (step)
            P_HEADER: begin
               if (idx == QD_HI_AT || idx == AN_HI_AT) hold = b;
               else if (idx == QD_LO_AT) qd_left = {hold, b};
               else if (idx == AN_LO_AT) an_left = {hold, b};
               idx++;
               if (idx >= HEADER_BYTES) begin
                  idx = 0;
                  step = (qd_left != 0 || an_left != 0) ? P_NAME_LEN : P_ANSWERS_DONE;
               end
            end
            P_NAME_LEN: begin
               if (b[7:6] == 2'b11) step = P_POINTER;
               else if (b[7:6] != 2'b00) go_bad();
               else if (b == 0) close_name();
               else begin
                  str_left = b;
                  step = P_LABEL;
               end
            end
            P_LABEL: begin
               str_left = str_left - 8'd1;
               if (str_left == 0) step = P_NAME_LEN;
            end
            P_POINTER: close_name();
            P_QUESTION_TAIL: begin
               idx++;
               if (idx >= QUESTION_TAIL) begin
                  idx = 0;
                  qd_left = qd_left - 16'd1;
                  step = (qd_left != 0 || an_left != 0) ? P_NAME_LEN : P_ANSWERS_DONE;
               end
            end
            P_ANSWER_TAIL: begin
               if (idx == RTYPE_HI_AT || idx == RDLEN_AT) hold = b;
               else if (idx == RTYPE_LO_AT) rtype = {hold, b};
               else if (idx == RDLEN_AT + 1) rd_left = {hold, b};
               idx++;
               if (idx >= ANSWER_TAIL) begin
                  idx = 0;
                  if (rtype == match_type) begin
                     found = 1;
                     if (rd_left == 0) begin
                        push_result(KIND_EOR, 8'h00, ST_OK);
                        close_answer();
                     end else begin
                        step = P_STRING_LEN;
                     end
                  end else if (rd_left == 0) begin
                     close_answer();
                  end else begin
                     step = P_RDATA_SKIP;
                  end
               end
            end
            P_RDATA_SKIP: begin
               rd_left = rd_left - 16'd1;
               if (rd_left == 0) close_answer();
            end
            P_STRING_LEN: begin
               rd_left = rd_left - 16'd1;
               if ({8'h00, b} > rd_left) go_bad();
               else if (b != 0) begin
                  str_left = b;
                  step = P_STRING_TEXT;
               end else if (rd_left == 0) begin
                  push_result(KIND_EOR, 8'h00, ST_OK);
                  close_answer();
               end
            end
            P_STRING_TEXT: begin
               push_result(KIND_TEXT, b, ST_OK);
               rd_left = rd_left - 16'd1;
               str_left = str_left - 8'd1;
               if (str_left == 0) begin
                  if (rd_left == 0) begin
                     push_result(KIND_EOR, 8'h00, ST_OK);
                     close_answer();
                  end else begin
                     step = P_STRING_LEN;
                  end
               end
            end
            default: ;
         endcase

         // Close the message with its status
         if (last) begin
            if (bad || step != P_ANSWERS_DONE) st = ST_BAD;
            else st = found ? ST_OK : ST_NONE;
            push_result(KIND_STATUS, 8'h00, st);
            restart();
         end
         if (owed_q.size() > owed_before) owed_q[owed_q.size() - 1].run_last = 1'b1;
      endfunction

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         errors++;
         if (errors <= PRINT_CAP)
            $display("%0t mismatch in %s: got %0h, expected %0h", $time, what, got, want);
      endtask

      // Compare one result transfer with the oldest owed result
      task check_result(logic [1:0] kind, logic [15:0] data, logic last);
         txt_result_type want;
         if (owed_q.size() == 0) begin
            report_mismatch("result with nothing owed", data, 0);
            return;
         end
         want = owed_q.pop_front();
         if (kind !== want.kind) report_mismatch("out_kind", kind, want.kind);
         if (data[7:0] !== want.text) report_mismatch("text_byte", data[7:0], want.text);
         if (data[9:8] !== want.st) report_mismatch("status", data[9:8], want.st);
         if (data[15:10] !== 6'h00) report_mismatch("tdata pad", data[15:10], 0);
         if (last !== want.run_last) report_mismatch("run_last", last, want.run_last);
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid, req_tready, req_tlast;
   logic [7:0]            req_tdata;
   logic                  rsp_tvalid, rsp_tready, rsp_tlast;
   logic [15:0]           rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]           csr_pwdata, csr_prdata;

   txt_scoreboard sb = new();
   byte_q_type    msg_q;
   byte_q_type    no_rdata;
   int            bytes_sent;
   int            quiet_cycles;
   bit            calm;
   bit            hold_req;

   dns_txt_answer_extractor_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #10 clock = ~clock;

   // Message building
   function automatic logic [7:0] rnd8();
      return 8'($urandom_range(255));
   endfunction

   function automatic void add_word(input logic [15:0] v);
      msg_q.push_back(v[15:8]);
      msg_q.push_back(v[7:0]);
   endfunction

   function automatic void add_header(input logic [15:0] qd, input logic [15:0] an);
      repeat (4) msg_q.push_back(rnd8());
      add_word(qd);
      add_word(an);
      repeat (4) msg_q.push_back(rnd8());
   endfunction

   // Up to two short labels, closed by a root byte or a compression pointer
   function automatic void add_name();
      int len;
      repeat ($urandom_range(2)) begin
         len = $urandom_range(1, 5);
         msg_q.push_back(8'(len));
         repeat (len) msg_q.push_back(rnd8());
      end
      if ($urandom_range(1)) begin
         msg_q.push_back(8'hC0 | 8'($urandom_range(63)));
         msg_q.push_back(rnd8());
      end else begin
         msg_q.push_back(8'h00);
      end
   endfunction

   function automatic byte_q_type random_rdata(input bit as_text);
      byte_q_type d;
      int         len;
      if (as_text) begin
         repeat ($urandom_range(3)) begin
            len = $urandom_range(5);
            d.push_back(8'(len));
            repeat (len) d.push_back(rnd8());
         end
      end else begin
         repeat ($urandom_range(5)) d.push_back(rnd8());
      end
      return d;
   endfunction

   // Name, type, random class and ttl, data length, data
   function automatic void add_record(input logic [15:0] rtype, input byte_q_type rdata);
      add_name();
      add_word(rtype);
      repeat (6) msg_q.push_back(rnd8());
      add_word(16'(rdata.size()));
      foreach (rdata[i]) msg_q.push_back(rdata[i]);
   endfunction

   // Stream side
   task automatic send_byte(input logic [7:0] b, input logic last);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_msg();
      foreach (msg_q[i]) send_byte(msg_q[i], i == msg_q.size() - 1);
      bytes_sent += msg_q.size();
      msg_q.delete();
   endtask

   // Well-formed response with random content; some get cut short or corrupted
   task automatic random_msg();
      int qd, an, pos;
      qd = $urandom_range(2);
      an = $urandom_range(3);
      add_header(16'(qd), 16'(an));
      repeat (qd) begin
         add_name();
         repeat (QUESTION_TAIL) msg_q.push_back(rnd8());
      end
      repeat (an) begin
         if ($urandom_range(1)) add_record(sb.match_type, random_rdata(1));
         else add_record(16'($urandom()), random_rdata(0));
      end
      repeat ($urandom_range(3)) msg_q.push_back(rnd8());
      case ($urandom_range(7))
         0: begin
            pos = $urandom_range(1, msg_q.size());
            msg_q = msg_q[0:pos-1];
         end
         1: begin
            pos = $urandom_range(msg_q.size() - 1);
            msg_q[pos] = rnd8();
         end
         default: ;
      endcase
      send_msg();
   endtask

   // Drop valid and wait until every owed result has been checked
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register side
   task automatic check_match_type(input logic [15:0] v);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= REG_MATCH_TYPE_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[15:0] !== v) sb.report_mismatch("match_type readback", csr_prdata, v);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_match_type(input logic [15:0] v);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= REG_MATCH_TYPE_ADDR;
      csr_pwdata  <= {16'($urandom()), v};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.match_type = v;
      check_match_type(v);
   endtask

   // Receiver: random stalls, a calm phase, and one long hold-off on request
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_req = 1'b0;
         end
         rsp_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Monitor every transfer and watch for a hung run
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tuser, rsp_tdata, rsp_tlast);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_psel && csr_penable && csr_pready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin
      logic [15:0] phase_types[4];
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tlast   <= 1'b0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_match_type(MATCH_TYPE_RESET);

      // Label, pointer, empty record, skipped record, empty strings, trailing bytes
      add_header(16'd1, 16'd4);
      msg_q.push_back(8'd6);
      repeat (6) msg_q.push_back(rnd8());
      msg_q.push_back(8'hC0);
      msg_q.push_back(8'h0C);
      repeat (QUESTION_TAIL) msg_q.push_back(rnd8());
      add_record(TYPE_TXT, no_rdata);
      add_record(TYPE_A, '{8'h01, 8'h02, 8'h03, 8'h04});
      add_record(TYPE_TXT, '{8'd2, 8'h00, 8'hFF, 8'd0});
      add_record(TYPE_TXT, '{8'd0, 8'd1, 8'h41});
      repeat (2) msg_q.push_back(rnd8());
      send_msg();

      // No answers at all, then only a non-matching answer
      add_header(16'd0, 16'd0);
      send_msg();
      add_header(16'd0, 16'd1);
      add_record(TYPE_A, random_rdata(0));
      send_msg();

      // Reserved label bits in a question and in an answer after emitted text
      add_header(16'd1, 16'd1);
      msg_q.push_back(8'h40);
      repeat (2) msg_q.push_back(rnd8());
      send_msg();
      add_header(16'd0, 16'd2);
      add_record(TYPE_TXT, '{8'd3, 8'h61, 8'h62, 8'h63});
      msg_q.push_back(8'h80);
      msg_q.push_back(rnd8());
      send_msg();

      // String length past the end of the record data
      add_header(16'd0, 16'd1);
      add_record(TYPE_TXT, '{8'd1, 8'h5A, 8'd255});
      send_msg();

      // Ends inside record text, inside the header, after one byte, inside questions
      add_header(16'd0, 16'd1);
      add_record(TYPE_TXT, '{8'd4, rnd8(), rnd8(), rnd8(), rnd8()});
      msg_q = msg_q[0:msg_q.size()-3];
      send_msg();
      add_header(16'hFFFF, 16'hFFFF);
      msg_q = msg_q[0:8];
      send_msg();
      msg_q.push_back(rnd8());
      send_msg();
      add_header(16'hFFFF, 16'd0);
      msg_q.push_back(8'h00);
      repeat (QUESTION_TAIL) msg_q.push_back(rnd8());
      send_msg();
      settle();

      // Random traffic under several match types; one calm phase, one hold-off
      phase_types = '{16'h0000, 16'hFFFF, 16'($urandom()), TYPE_TXT};
      foreach (phase_types[p]) begin
         set_match_type(phase_types[p]);
         calm = (p == 1);
         if (p == 2) hold_req = 1'b1;
         bytes_sent = 0;
         while (bytes_sent < PHASE_BYTES) random_msg();
         settle();
      end
      calm = 1'b0;

      if (sb.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule
